// ===== src/cgpt_pkg.sv =====
// shared types and constants of the four-corner pixel tint block
// no dependencies
package cgpt_pkg;

   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = $clog2(MAX_DIM) + 1;   // width of a size register
   localparam int POS_W   = $clog2(MAX_DIM);       // column / row position
   localparam int QUO_W   = 8;                     // quotient never exceeds a byte span
   localparam int NUM_W   = POS_W + QUO_W;         // |pos * (b - a)|
   localparam int LANES   = 4;

   localparam logic [31:0] NEUTRAL_TINT = 32'hFF808080;
   localparam logic [31:0] WHITE_TINT   = 32'hFFFFFFFF;
   localparam logic [7:0]  BYTE_MAX     = 8'hFF;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_ALPHA   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT       = 3'd6;

   typedef struct packed {
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] out_alpha;
      logic       line_end;
      logic       frame_end;
   } rsp_type;

   // classified pixel handed from front to back
   typedef struct packed {
      req_type          pixel;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] span_x;
      logic [POS_W-1:0] span_y;
      logic             last_col;
      logic             last_row;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_SCALE
   } back_state_type;

   // clamp a size register to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage

// ===== src/cgpt_front.sv =====
// front end: column/row tracking and classification of each pixel
// depends on cgpt_pkg
module cgpt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cgpt_pkg::req_type          pixel,
   input  logic [cgpt_pkg::DIM_W-1:0] frame_width,
   input  logic [cgpt_pkg::DIM_W-1:0] frame_height,
   output cgpt_pkg::work_type         work
);
   import cgpt_pkg::*;

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] w, h;
   logic [POS_W-1:0] wm1, hm1;

   // effective sizes and positions
   always_comb begin
      w = eff_size(frame_width);
      h = eff_size(frame_height);
      wm1 = POS_W'(w - DIM_W'(1));
      hm1 = POS_W'(h - DIM_W'(1));
      work.pixel    = pixel;
      work.pos_x    = (col_ff < wm1) ? col_ff : wm1;
      work.pos_y    = (row_ff < hm1) ? row_ff : hm1;
      work.span_x   = (wm1 == '0) ? POS_W'(1) : wm1;
      work.span_y   = (hm1 == '0) ? POS_W'(1) : hm1;
      work.last_col = col_ff >= wm1;
      work.last_row = row_ff >= hm1;
   end

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (work.last_col) begin
            col_in = '0;
            row_in = work.last_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== src/cgpt_work_q.sv =====
// two-entry queue of classified pixels between front and back
// depends on cgpt_pkg
module cgpt_work_q (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cgpt_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output cgpt_pkg::work_type head
);
   import cgpt_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   // pointers and fill level
   always_comb begin
      full  = cnt_ff == 2'd2;
      empty = cnt_ff == 2'd0;
      head  = mem_ff[rd_ff];
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ===== src/cgpt_back.sv =====
// back end: corner interpolation with a shared 8-step divider per lane,
// tint scaling and the result queue; depends on cgpt_pkg
module cgpt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_empty,
   input  cgpt_pkg::work_type work_head,
   output logic               work_pop,
   input  logic [31:0]        corner_tl,
   input  logic [31:0]        corner_tr,
   input  logic [31:0]        corner_br,
   input  logic [31:0]        corner_bl,
   input  logic               half_alpha,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output cgpt_pkg::rsp_type  rsp_data
);
   import cgpt_pkg::*;

   back_state_type state_ff, state_in;
   work_type       item_ff, item_in;
   logic [1:0]     phase_ff, phase_in;
   logic [2:0]     bit_ff, bit_in;

   logic [7:0]       base_ff [LANES];
   logic [7:0]       base_in [LANES];
   logic             neg_ff  [LANES];
   logic             neg_in  [LANES];
   logic [NUM_W-1:0] rem_ff  [LANES];
   logic [NUM_W-1:0] rem_in  [LANES];
   logic [7:0]       quo_ff  [LANES];
   logic [7:0]       quo_in  [LANES];
   logic [7:0]       left_ff [LANES];
   logic [7:0]       left_in [LANES];
   logic [7:0]       right_ff[LANES];
   logic [7:0]       right_in[LANES];

   rsp_type    rq_ff [2];
   logic       rq_wr_ff, rq_rd_ff;
   logic [1:0] rq_cnt_ff;
   logic       rq_push;
   rsp_type    result;

   logic [POS_W-1:0] pos, span;
   logic [7:0]       a_val [LANES];
   logic [7:0]       b_val [LANES];
   logic [8:0]       diff  [LANES];
   logic [7:0]       mag   [LANES];
   logic [NUM_W-1:0] shd;
   logic [7:0]       lerp_out [LANES];
   logic [7:0]       src   [LANES];
   logic [7:0]       outv  [LANES];
   logic [15:0]      prod;
   logic [16:0]      p255;
   logic [8:0]       q;
   logic             pass;

   // operand selection per phase: left edge, right edge, across the row
   always_comb begin
      pos  = (phase_ff == 2'd2) ? item_ff.pos_x : item_ff.pos_y;
      span = (phase_ff == 2'd2) ? item_ff.span_x : item_ff.span_y;
      shd  = NUM_W'(span) << bit_ff;
      src[0] = item_ff.pixel.in_red;
      src[1] = item_ff.pixel.in_green;
      src[2] = item_ff.pixel.in_blue;
      src[3] = item_ff.pixel.in_alpha;
      for (int k = 0; k < LANES; k++) begin
         case (phase_ff)
            2'd0: begin
               a_val[k] = corner_tl[8*k +: 8];
               b_val[k] = corner_bl[8*k +: 8];
            end
            2'd1: begin
               a_val[k] = corner_tr[8*k +: 8];
               b_val[k] = corner_br[8*k +: 8];
            end
            default: begin
               a_val[k] = left_ff[k];
               b_val[k] = right_ff[k];
            end
         endcase
         diff[k] = {1'b0, b_val[k]} - {1'b0, a_val[k]};
         mag[k]  = diff[k][8] ? 8'(-diff[k]) : diff[k][7:0];
         lerp_out[k] = neg_ff[k] ? base_ff[k] - quo_ff[k] : base_ff[k] + quo_ff[k];
      end
   end

   // passthrough test and output scaling
   always_comb begin
      pass = (corner_tl == NEUTRAL_TINT && corner_tr == NEUTRAL_TINT &&
              corner_br == NEUTRAL_TINT && corner_bl == NEUTRAL_TINT) ||
             ((corner_tl & corner_tr & corner_br & corner_bl) == WHITE_TINT);
      prod = '0;
      p255 = '0;
      q    = '0;
      for (int k = 0; k < LANES; k++) begin
         prod = lerp_out[k] * src[k];
         // exact divide by 255 for a 16-bit product
         p255 = {1'b0, prod} + 17'(prod >> 8) + 17'd1;
         q = half_alpha ? prod[15:7] : {1'b0, p255[15:8]};
         if (pass) outv[k] = src[k];
         else outv[k] = (q > 9'(BYTE_MAX)) ? BYTE_MAX : q[7:0];
      end
      result.out_red   = outv[0];
      result.out_green = outv[1];
      result.out_blue  = outv[2];
      result.out_alpha = outv[3];
      result.line_end  = item_ff.last_col;
      result.frame_end = item_ff.last_col && item_ff.last_row;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      work_pop = 1'b0;
      rq_push  = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         base_in[k]  = base_ff[k];
         neg_in[k]   = neg_ff[k];
         rem_in[k]   = rem_ff[k];
         quo_in[k]   = quo_ff[k];
         left_in[k]  = left_ff[k];
         right_in[k] = right_ff[k];
      end
      case (state_ff)
         ST_IDLE: begin
            if (!work_empty && rq_cnt_ff != 2'd2) begin
               item_in  = work_head;
               work_pop = 1'b1;
               phase_in = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int k = 0; k < LANES; k++) begin
               base_in[k] = a_val[k];
               neg_in[k]  = diff[k][8];
               rem_in[k]  = NUM_W'(pos) * NUM_W'(mag[k]);
               quo_in[k]  = '0;
            end
            bit_in   = 3'd7;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int k = 0; k < LANES; k++) begin
               if (rem_ff[k] >= shd) begin
                  rem_in[k]         = rem_ff[k] - shd;
                  quo_in[k][bit_ff] = 1'b1;
               end
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) state_in = ST_FIN;
         end
         ST_FIN: begin
            for (int k = 0; k < LANES; k++) begin
               if (phase_ff == 2'd0) left_in[k] = lerp_out[k];
               if (phase_ff == 2'd1) right_in[k] = lerp_out[k];
            end
            if (phase_ff == 2'd2) begin
               state_in = ST_SCALE;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_SCALE: begin
            rq_push  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      phase_ff <= phase_in;
      bit_ff   <= bit_in;
      for (int k = 0; k < LANES; k++) begin
         base_ff[k]  <= base_in[k];
         neg_ff[k]   <= neg_in[k];
         rem_ff[k]   <= rem_in[k];
         quo_ff[k]   <= quo_in[k];
         left_ff[k]  <= left_in[k];
         right_ff[k] <= right_in[k];
      end
   end

   // result queue
   assign rsp_empty = rq_cnt_ff == 2'd0;
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= '0;
      end else begin
         if (rq_push) rq_wr_ff <= ~rq_wr_ff;
         if (rsp_pop && !rsp_empty) rq_rd_ff <= ~rq_rd_ff;
         rq_cnt_ff <= rq_cnt_ff + {1'b0, rq_push} - {1'b0, rsp_pop && !rsp_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) rq_ff[rq_wr_ff] <= result;
   end

endmodule

// ===== src/corner_gradient_pixel_tint.sv =====
// top level of the four-corner pixel tint block: configuration registers,
// front end, work queue and back end; depends on cgpt_pkg and submodules
//
// usage:
// - pixels enter in raster order on req_data: a transaction happens when
//   req_push is high and req_full is low
// - results leave on rsp_data in the same order: the head is valid while
//   rsp_empty is low and is taken when rsp_pop is high
// - registers are written over csr_valid/csr_ready (ready is always high);
//   write only while no pixel is in flight
// - each pixel passes through the back end in order: a load step, three
//   interpolation passes (left edge, right edge, across the row), each a
//   multiply, an 8-step restoring divide per color lane and a final add,
//   then a scaling step; the back end takes no new pixel until the last
//   one is scaled and waits while its result queue is full
// - the front end tracks column and row and the work queue holds up to two
//   classified pixels; the back end holds up to two results, so a stalled
//   receiver backs up into req_full without losing anything
// - reset clears counters and queues and loads the default corners,
//   divide-by-255 mode and a 1x1 frame
module corner_gradient_pixel_tint (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  cgpt_pkg::req_type              req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output cgpt_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cgpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import cgpt_pkg::*;

   logic [31:0]      tl_ff, tr_ff, br_ff, bl_ff;
   logic             half_ff;
   logic [DIM_W-1:0] width_ff, height_ff;

   logic     accept;
   work_type front_work;
   work_type q_head;
   logic     q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff     <= NEUTRAL_TINT;
         tr_ff     <= NEUTRAL_TINT;
         br_ff     <= NEUTRAL_TINT;
         bl_ff     <= NEUTRAL_TINT;
         half_ff   <= 1'b0;
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TOP_LEFT:     tl_ff     <= csr_data;
            REG_TOP_RIGHT:    tr_ff     <= csr_data;
            REG_BOTTOM_RIGHT: br_ff     <= csr_data;
            REG_BOTTOM_LEFT:  bl_ff     <= csr_data;
            REG_HALF_ALPHA:   half_ff   <= csr_data[0];
            REG_WIDTH:        width_ff  <= csr_data[DIM_W-1:0];
            REG_HEIGHT:       height_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   cgpt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (accept),
      .pixel        (req_data),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .work         (front_work)
   );

   cgpt_work_q u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_work),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   cgpt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (q_empty),
      .work_head  (q_head),
      .work_pop   (q_pop),
      .corner_tl  (tl_ff),
      .corner_tr  (tr_ff),
      .corner_br  (br_ff),
      .corner_bl  (bl_ff),
      .half_alpha (half_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
